// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every edge outside reset
`define CHK_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("%m failed");
// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("%m failed");
`endif

// ===== rtl/tla_pkg.sv =====
// types and codes for the toroidal life automaton
// no dependencies
package tla_pkg;
   localparam logic [1:0] MODE_READ   = 2'd0;
   localparam logic [1:0] MODE_KILL   = 2'd1;
   localparam logic [1:0] MODE_REVIVE = 2'd2;
   localparam logic [1:0] MODE_STEP   = 2'd3;
   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;
   localparam int SURVIVE_LO = 2;
   localparam int SURVIVE_HI = 3;
   localparam int BIRTH_COUNT = 3;

   typedef struct packed {
      logic [1:0]        mode;
      logic signed [7:0] row;
      logic signed [7:0] col;
   } req_type;

   typedef struct packed {
      logic alive;
      logic invalid;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear;    // clear one row at scan address
      logic rd_cur;   // cell-op row read flag, never set or used
      logic wr_cell;  // write back modified row
      logic load_win; // fetch next window row
      logic shift_win;
      logic commit;   // write computed row
      logic keep_top; // save old first row
      logic load_top; // last row takes saved first row as lower neighbor
   } cmd_type;
endpackage

// ===== rtl/toroidal_life_automaton.sv =====
// read/kill/revive pass through S_CELL and S_CELL2 before the reply; a bad address is answered from idle
// step: one cell per cycle from a three-row window
// one item at a time; a write to the rows or cols register clears the grid
// reset is synchronous: dims to 64, then the grid is cleared
// input and register port are held off while that clear runs
module toroidal_life_automaton #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tla_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tla_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_wdata
);
   import tla_pkg::*;
   localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   cmd_type cmd;
   logic [RW-1:0] addr, wr_addr;
   logic [CW-1:0] cell_col, step_col;
   logic [CW:0] ncols;
   logic set_val, first_col, cell_bit, row_done, cv;

   assign cv = csr_valid && csr_index[1] == 1'b0;

   tla_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_valid(cv), .csr_ready, .csr_index(csr_index[0]), .csr_wdata,
      .cmd, .addr, .wr_addr, .cell_col, .step_col, .ncols, .set_val, .first_col,
      .cell_bit, .row_done);

   tla_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
      .clock, .cmd, .addr, .wr_addr, .cell_col, .step_col, .ncols, .set_val,
      .first_col, .cell_bit, .row_done);
endmodule

// ===== rtl/tla_datapath.sv =====
// grid memory and row-window life evaluation
// depends on tla_pkg
module tla_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64,
   parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   parameter int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic                clock,
   input  tla_pkg::cmd_type    cmd,
   input  logic [RW-1:0]       addr,
   input  logic [RW-1:0]       wr_addr,
   input  logic [CW-1:0]       cell_col,
   input  logic [CW-1:0]       step_col,
   input  logic [CW:0]         ncols,
   input  logic                set_val,
   input  logic                first_col,
   output logic                cell_bit,
   output logic                row_done
);
   import tla_pkg::*;
   logic [MAX_COLS-1:0] mem [MAX_ROWS];
   logic [MAX_COLS-1:0] rd_ff;
   logic [MAX_COLS-1:0] up_ff, mid_ff, dn_ff, new_ff, new_in, top_ff, cell_row;
   logic [CW-1:0] lf, rt;
   logic [3:0] cnt;
   logic nb;

   always_comb begin
      cell_row = rd_ff;
      cell_row[cell_col] = set_val;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) mem[wr_addr] <= '0;
      else if (cmd.wr_cell) mem[wr_addr] <= cell_row;
      else if (cmd.commit) mem[wr_addr] <= new_ff;
      rd_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.shift_win) begin
         up_ff  <= mid_ff;
         mid_ff <= dn_ff;
      end
      if (cmd.load_win) dn_ff <= cmd.load_top ? top_ff : rd_ff;
      if (cmd.keep_top) top_ff <= mid_ff;
      new_ff <= new_in;
   end

   always_comb begin
      lf = (step_col == '0) ? CW'(ncols - 1'b1) : CW'(step_col - 1'b1);
      rt = ({1'b0, step_col} + 1'b1 == ncols) ? '0 : CW'(step_col + 1'b1);
      cnt = 4'(up_ff[lf]) + 4'(mid_ff[lf]) + 4'(dn_ff[lf]) + 4'(up_ff[step_col])
          + 4'(dn_ff[step_col]) + 4'(up_ff[rt]) + 4'(mid_ff[rt]) + 4'(dn_ff[rt]);
      nb = mid_ff[step_col] ? (cnt == 4'(SURVIVE_LO) || cnt == 4'(SURVIVE_HI))
                            : (cnt == 4'(BIRTH_COUNT));
      new_in = first_col ? mid_ff : new_ff;
      new_in[step_col] = nb;
   end

   assign cell_bit = rd_ff[cell_col];
   assign row_done = ({1'b0, step_col} + 1'b1 == ncols);
endmodule

// ===== rtl/tla_ctrl.sv =====
// sequencer for cell ops, generation scan and grid clear
// depends on tla_pkg
module tla_ctrl #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64,
   parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
   parameter int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tla_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tla_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [6:0]        csr_wdata,
   output tla_pkg::cmd_type  cmd,
   output logic [RW-1:0]     addr,
   output logic [RW-1:0]     wr_addr,
   output logic [CW-1:0]     cell_col,
   output logic [CW-1:0]     step_col,
   output logic [CW:0]       ncols,
   output logic              set_val,
   output logic              first_col,
   input  logic              cell_bit,
   input  logic              row_done
);
   import tla_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_CELL = 3'd1, S_CLEAR = 3'd2,
      S_PRE = 3'd3, S_LOAD = 3'd4, S_COL = 3'd5, S_RESP = 3'd6, S_CELL2 = 3'd7;
   localparam int RV = RW + 1;

   logic [2:0] state_ff, state_in;
   logic [6:0] rows_ff, cols_ff;
   logic [RV-1:0] nr;
   logic [RW-1:0] row_ff, row_in, cnt_ff, cnt_in;
   logic [CW-1:0] col_ff, col_in, sc_ff, sc_in;
   logic [1:0] mode_ff, mode_in, pre_ff, pre_in;
   logic rv_ff, rv_in;
   rsp_type out_ff, out_in;
   logic bad;

   function automatic logic [RV-1:0] used_r(input logic [6:0] v);
      if (v == 0) return RV'(1);
      if (32'(v) > MAX_ROWS) return RV'(MAX_ROWS);
      return RV'(v);
   endfunction
   function automatic logic [CW:0] used_c(input logic [6:0] v);
      if (v == 0) return (CW+1)'(1);
      if (32'(v) > MAX_COLS) return (CW+1)'(MAX_COLS);
      return (CW+1)'(v);
   endfunction
   function automatic logic [RW-1:0] wrap_inc(input logic [RW-1:0] r, input logic [RV-1:0] n);
      return ({1'b0, r} + 1'b1 == n) ? '0 : RW'(r + 1'b1);
   endfunction

   assign nr = used_r(rows_ff);
   assign ncols = used_c(cols_ff);
   assign bad = req_data.row[7] || req_data.col[7] ||
                16'(req_data.row) >= 16'(nr) || 16'(req_data.col) >= 16'(ncols);
   assign csr_ready = (state_ff == S_IDLE) && !rv_ff;
   assign req_stall = (state_ff != S_IDLE) || rv_ff || csr_valid;
   assign rsp_valid = rv_ff;
   assign rsp_data = out_ff;
   assign cell_col = col_ff;
   assign step_col = sc_ff;
   assign set_val = (mode_ff == MODE_REVIVE);
   assign first_col = (sc_ff == '0);

   always_comb begin
      state_in = state_ff; row_in = row_ff; col_in = col_ff; cnt_in = cnt_ff;
      sc_in = sc_ff; mode_in = mode_ff; pre_in = pre_ff; rv_in = rv_ff;
      out_in = out_ff; cmd = '0; addr = row_ff; wr_addr = row_ff;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               cnt_in = '0;
               state_in = S_CLEAR;
            end else if (req_valid && !req_stall) begin
               out_in = '0;
               mode_in = req_data.mode;
               row_in = RW'(req_data.row);
               col_in = CW'(req_data.col);
               if (req_data.mode == MODE_STEP) begin
                  // window rows: last, first, second
                  row_in = RW'(nr - 1'b1);
                  cnt_in = '0;
                  pre_in = '0;
                  state_in = S_PRE;
               end else if (bad) begin
                  out_in.invalid = 1'b1;
                  rv_in = 1'b1;
               end else state_in = S_CELL;
            end
         end
         S_CELL: state_in = S_CELL2; // memory read latency
         S_CELL2: begin
            if (mode_ff == MODE_READ) out_in.alive = cell_bit;
            else cmd.wr_cell = 1'b1;
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            wr_addr = cnt_ff;
            cmd.clear = 1'b1;
            cnt_in = RW'(cnt_ff + 1'b1);
            if (32'(cnt_ff) == MAX_ROWS - 1) state_in = S_IDLE;
         end
         S_PRE: begin
            // issue reads for up, mid, dn; addr in row_ff
            addr = row_ff;
            if (pre_ff != 0) begin
               cmd.load_win = 1'b1;
               cmd.shift_win = 1'b1;
            end
            row_in = wrap_inc(row_ff, nr);
            pre_in = pre_ff + 1'b1;
            if (pre_ff == 2'd2) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_win = 1'b1;
            cmd.shift_win = 1'b1;
            // first row is already rewritten when the last row needs it
            cmd.load_top = (cnt_ff != '0) && ({1'b0, cnt_ff} + 1'b1 == nr);
            sc_in = '0;
            state_in = S_COL;
         end
         S_COL: begin
            sc_in = CW'(sc_ff + 1'b1);
            if (row_done) state_in = S_RESP;
         end
         S_RESP: begin
            // new_ff holds computed row cnt_ff; row_ff addresses next dn row
            wr_addr = cnt_ff;
            cmd.commit = 1'b1;
            cmd.keep_top = (cnt_ff == '0);
            addr = row_ff;
            if ({1'b0, cnt_ff} + 1'b1 == nr) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cnt_in = RW'(cnt_ff + 1'b1);
               row_in = wrap_inc(row_ff, nr);
               state_in = S_LOAD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         rows_ff <= 7'd64;
         cols_ff <= 7'd64;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROWS) rows_ff <= csr_wdata;
            else cols_ff <= csr_wdata;
         end
      end
      row_ff <= row_in; col_ff <= col_in; sc_ff <= sc_in;
      mode_ff <= mode_in; pre_ff <= pre_in; out_ff <= out_in;
   end
endmodule

// ===== rtl/tla_checker.sv =====
// port-level checks for the toroidal life automaton
// depends on tla_pkg and assert_macros.svh
`include "assert_macros.svh"
module tla_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tla_pkg::rsp_type rsp_data
);
   `CHK_ALWAYS(a_one_flag, clock, reset, !rsp_valid || !(rsp_data.alive && rsp_data.invalid))
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CHK_ALWAYS(a_no_accept_busy, clock, reset, !(rsp_valid && !req_stall))
   `CHK_NEXT(a_stall_after_take, clock, reset, req_valid && !req_stall, req_stall)
endmodule

bind toroidal_life_automaton tla_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data);

// ===== sim/toroidal_life_automaton_test.sv =====
// testbench for the toroidal life automaton: directed table, then random cell operations
// and generations checked against an in-bench grid predictor
// depends on rtl/tla_pkg.sv and rtl/toroidal_life_automaton.sv
module toroidal_life_automaton_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tla_pkg::*;

   localparam logic [1:0] IDX_ROWS  = {1'b0, CSR_ROWS};
   localparam logic [1:0] IDX_COLS  = {1'b0, CSR_COLS};
   localparam logic [1:0] IDX_SPARE = 2'd2;
   localparam int GRID_N = 64;

   typedef struct {
      logic [1:0]  mode;
      logic [7:0]  row;
      logic [7:0]  col;
      bit          typed;
      logic        alive;
      logic        invalid;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [6:0] csr_wdata = '0;

   logic [GRID_N-1:0] life_grid [GRID_N];
   logic [6:0] rows_reg, cols_reg;
   rsp_type cell_replies[$];
   int errs = 0;
   int replies_seen = 0;
   bit calm = 0;

   toroidal_life_automaton dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #30ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int used_dim(logic [6:0] v);
      if (v == 0) return 1;
      if (v > GRID_N) return GRID_N;
      return int'(v);
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 55) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic advance_life();
      logic [GRID_N-1:0] nxt [GRID_N];
      int nr, nc, up, dn, lf, rt, n;
      nr = used_dim(rows_reg);
      nc = used_dim(cols_reg);
      nxt = life_grid;
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            up = (r == 0) ? nr - 1 : r - 1;
            dn = (r + 1 == nr) ? 0 : r + 1;
            lf = (c == 0) ? nc - 1 : c - 1;
            rt = (c + 1 == nc) ? 0 : c + 1;
            n = life_grid[up][lf] + life_grid[r][lf] + life_grid[dn][lf] + life_grid[up][c]
              + life_grid[dn][c] + life_grid[up][rt] + life_grid[r][rt] + life_grid[dn][rt];
            if (life_grid[r][c]) begin
               if (n != SURVIVE_LO && n != SURVIVE_HI) nxt[r][c] = 1'b0;
            end else if (n == BIRTH_COUNT) begin
               nxt[r][c] = 1'b1;
            end
         end
      end
      life_grid = nxt;
   endtask

   task automatic predict_cell_op(input req_type q, output rsp_type p);
      int r, c;
      r = q.row;
      c = q.col;
      p = '0;
      if (q.mode == MODE_STEP) begin
         advance_life();
      end else if (r < 0 || c < 0 || r >= used_dim(rows_reg) || c >= used_dim(cols_reg)) begin
         p.invalid = 1'b1;
      end else if (q.mode == MODE_READ) begin
         p.alive = life_grid[r][c];
      end else begin
         life_grid[r][c] = (q.mode == MODE_REVIVE);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [6:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == IDX_ROWS || idx == IDX_COLS) begin
         for (int r = 0; r < GRID_N; r++) life_grid[r] = '0;
         if (idx == IDX_ROWS) rows_reg = val;
         else cols_reg = val;
      end
   endtask

   task automatic send_item(input vector_type v);
      req_type q;
      rsp_type p;
      int g;
      q.mode = v.mode;
      q.row = v.row;
      q.col = v.col;
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_cell_op(q, p);
      if (v.typed) begin
         p.alive = v.alive;
         p.invalid = v.invalid;
      end
      cell_replies.push_back(p);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cell_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic vector_type random_item();
      vector_type v;
      int p, nr, nc;
      nr = used_dim(rows_reg);
      nc = used_dim(cols_reg);
      p = $urandom_range(0, 99);
      v.typed = 0;
      v.alive = 0;
      v.invalid = 0;
      if (p < 35) v.mode = MODE_REVIVE;
      else if (p < 65) v.mode = MODE_READ;
      else if (p < 85) v.mode = MODE_KILL;
      else if (p < 85 + ((nr * nc > 256) ? 4 : 15)) v.mode = MODE_STEP;
      else v.mode = MODE_READ;
      if ($urandom_range(0, 99) < 80) begin
         v.row = 8'($urandom_range(0, nr - 1));
         v.col = 8'($urandom_range(0, nc - 1));
      end else begin
         v.row = 8'($urandom_range(0, 255));
         v.col = 8'($urandom_range(0, 255));
      end
      return v;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         replies_seen <= replies_seen + 1;
         if (cell_replies.size() == 0) begin
            $error("unexpected transfer alive=%0b invalid=%0b", rsp_data.alive, rsp_data.invalid);
            errs++;
         end else begin
            e = cell_replies.pop_front();
            if (rsp_data.alive !== e.alive) begin
               $error("alive: expected %0b, got %0b", e.alive, rsp_data.alive);
               errs++;
            end
            if (rsp_data.invalid !== e.invalid) begin
               $error("invalid: expected %0b, got %0b", e.invalid, rsp_data.invalid);
               errs++;
            end
         end
      end
   end

   initial begin
      bit held;
      held = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held && replies_seen >= 30) begin
            held = 1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= (gap_len() > 0);
         end
      end
   end

   initial begin
      vector_type dirs[$];
      logic [6:0] phase_rows[$];
      logic [6:0] phase_cols[$];
      dirs = '{
         '{MODE_READ,   8'd0,   8'd0,   1, 0, 0},
         '{MODE_READ,   8'd63,  8'd63,  1, 0, 0},
         '{MODE_READ,   8'hFF,  8'd0,   1, 0, 1},
         '{MODE_READ,   8'd0,   8'h80,  1, 0, 1},
         '{MODE_READ,   8'd64,  8'd0,   1, 0, 1},
         '{MODE_READ,   8'd127, 8'd127, 1, 0, 1},
         '{MODE_REVIVE, 8'd0,   8'd0,   1, 0, 0},
         '{MODE_READ,   8'd0,   8'd0,   0, 0, 0},
         '{MODE_REVIVE, 8'd0,   8'd63,  0, 0, 0},
         '{MODE_REVIVE, 8'd63,  8'd0,   0, 0, 0},
         '{MODE_REVIVE, 8'd63,  8'd63,  0, 0, 0},
         '{MODE_KILL,   8'hFF,  8'd5,   1, 0, 1},
         '{MODE_REVIVE, 8'd0,   8'd64,  1, 0, 1},
         '{MODE_STEP,   8'hAA,  8'h55,  1, 0, 0},
         '{MODE_READ,   8'd0,   8'd0,   0, 0, 0},
         '{MODE_REVIVE, 8'd10,  8'd10,  0, 0, 0},
         '{MODE_REVIVE, 8'd10,  8'd11,  0, 0, 0},
         '{MODE_REVIVE, 8'd10,  8'd12,  0, 0, 0},
         '{MODE_STEP,   8'd0,   8'd0,   1, 0, 0},
         '{MODE_READ,   8'd9,   8'd11,  0, 0, 0},
         '{MODE_READ,   8'd11,  8'd11,  0, 0, 0},
         '{MODE_KILL,   8'd10,  8'd11,  0, 0, 0},
         '{MODE_STEP,   8'd0,   8'd0,   0, 0, 0},
         '{MODE_READ,   8'd10,  8'd11,  0, 0, 0}
      };
      phase_rows = '{7'd1, 7'd2, 7'd0, 7'd64, 7'd127, 7'd5, 7'd3, 7'd8};
      phase_cols = '{7'd1, 7'd2, 7'd64, 7'd1, 7'd0, 7'd7, 7'd127, 7'd8};
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      for (int r = 0; r < GRID_N; r++) life_grid[r] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_write(IDX_ROWS, 7'd64);
      csr_write(IDX_COLS, 7'd64);
      calm = 1;
      foreach (dirs[i]) send_item(dirs[i]);
      drain();
      for (int ph = 0; ph < phase_rows.size(); ph++) begin
         calm = (ph % 3 == 1);
         csr_write(IDX_SPARE, 7'h55);
         csr_write(IDX_ROWS, phase_rows[ph]);
         csr_write(IDX_COLS, phase_cols[ph]);
         for (int k = 0; k < ((ph == 3 || ph == 4) ? 10 : 17); k++) send_item(random_item());
         drain();
      end
      if (errs == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tla_pkg.sv
rtl/tla_datapath.sv
rtl/tla_ctrl.sv
rtl/toroidal_life_automaton.sv
rtl/tla_checker.sv
sim/toroidal_life_automaton_test.sv
